[hdl/sgns_pkg.sv]
`default_nettype none
package sgns_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned WIDTH_W    = 12;
  localparam int unsigned HEIGHT_W   = 13;
  localparam int unsigned MIN_SIZE   = 7;
  localparam int unsigned BORDER     = 3;
  localparam int unsigned PADDR_W    = 3;

  localparam int unsigned SUM_W      = 21;
  localparam int unsigned RES_W      = 22;
  localparam int unsigned MAG_W      = 11;
  localparam int unsigned SQRT_STEPS = 11;

  localparam logic [MAG_W-1:0] CLAMP_MAX = MAG_W'(255);
  localparam logic [25:0] TAN67_Q24 = 26'd40503782;
  localparam logic [22:0] TAN22_Q24 = 23'd6949350;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // direction bins
  typedef enum logic [1:0] {
    DIR_VERT  = 2'd0,
    DIR_BACK  = 2'd1,
    DIR_HORZ  = 2'd2,
    DIR_SLASH = 2'd3
  } dir_t;

  typedef struct packed {
    logic [SUM_W-1:0] rem;
    logic [RES_W-1:0] res;
  } sq_t;

  // one digit of the restoring square root, step k of SQRT_STEPS
  function automatic sq_t sqrt_step(sq_t s, int unsigned k);
    logic [RES_W-1:0] bitv;
    logic [RES_W-1:0] trial;
    sq_t o;
    bitv  = RES_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    trial = s.res + bitv;
    if ({1'b0, s.rem} >= trial) begin
      o.rem = SUM_W'({1'b0, s.rem} - trial);
      o.res = (s.res >> 1) + bitv;
    end else begin
      o.rem = s.rem;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

[hdl/sgns_sqrt.sv]
`default_nettype none
// floor square root over two register stages, sa and sb; root is combinational from sb
module sgns_sqrt (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [sgns_pkg::SUM_W-1:0]   value,
  output logic      [sgns_pkg::MAG_W-1:0]   root
);

  sgns_pkg::sq_t a0, a1, a2, a3, a4;
  sgns_pkg::sq_t b1, b2, b3, b4;
  sgns_pkg::sq_t c1, c2, c3;
  sgns_pkg::sq_t sa, sb;

  always_comb begin
    a0.rem = value;
    a0.res = '0;
    a1 = sgns_pkg::sqrt_step(a0, 0);
    a2 = sgns_pkg::sqrt_step(a1, 1);
    a3 = sgns_pkg::sqrt_step(a2, 2);
    a4 = sgns_pkg::sqrt_step(a3, 3);
    b1 = sgns_pkg::sqrt_step(sa, 4);
    b2 = sgns_pkg::sqrt_step(b1, 5);
    b3 = sgns_pkg::sqrt_step(b2, 6);
    b4 = sgns_pkg::sqrt_step(b3, 7);
    c1 = sgns_pkg::sqrt_step(sb, 8);
    c2 = sgns_pkg::sqrt_step(c1, 9);
    c3 = sgns_pkg::sqrt_step(c2, 10);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa <= a4;
      sb <= b4;
    end
  end

  assign root = c3.res[sgns_pkg::MAG_W-1:0];

endmodule
`default_nettype wire

[hdl/sobel_gradient_nonmax_suppress_core.sv]
`default_nettype none
// Sobel gradient magnitude with non-maximum suppression over a raster pixel
// stream. One pixel is taken every clock while the input is not stalled; the
// result for pixel j leaves with the transfer of pixel j+2w+2 through a
// nine-stage pipeline. Two line memories hold the state: a 2048x16 pixel
// memory (two rows) read as a pixel is accepted and written as it leaves
// stage 1, and a 2048x24 memory holding two magnitude rows and one direction
// row, read and written at the tail of the pipeline; both do one read and one
// write per cycle, which sets the one-pixel-per-clock rate. The input is
// stalled only while the output holds a result that is stalled and the last
// stage has another one ready. frame_start restarts the position counters;
// the three-pixel border gives zeros and the last 2w+2 results of a frame
// are not produced. Registers: image_width at 0x0, image_height at 0x4,
// clamped internally to 7..2048 and 7..4096. No memory clearing after reset.
module sobel_gradient_nonmax_suppress_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sgns_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    pixel,
  input  wire logic                          frame_start,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [7:0]                    edge_value,
  output logic                               last_of_frame
);

  localparam int unsigned CW = sgns_pkg::COL_W;
  localparam int unsigned RW = sgns_pkg::ROW_W;
  localparam int unsigned WW = sgns_pkg::WIDTH_W;
  localparam int unsigned HW = sgns_pkg::HEIGHT_W;
  localparam int unsigned MW = sgns_pkg::MAG_W;

  typedef struct packed {
    logic [CW-1:0] c;
    logic [CW-1:0] mc;
    logic          grad_margin;
    logic          sup_margin;
    logic          emit;
    logic          last;
  } item_t;

  // configuration
  logic [WW-1:0] image_width;
  logic [HW-1:0] image_height;
  logic          cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WW'(640);
      image_height <= HW'(480);
    end else if (cfg_write) begin
      case (paddr[2])
        sgns_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[WW-1:0];
        sgns_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[HW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      sgns_pkg::REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      sgns_pkg::REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:                    prdata = '0;
    endcase
  end

  logic [WW-1:0] w;
  logic [HW-1:0] h;

  always_comb begin
    if (image_width < WW'(sgns_pkg::MIN_SIZE))       w = WW'(sgns_pkg::MIN_SIZE);
    else if (image_width > WW'(sgns_pkg::MAX_WIDTH)) w = WW'(sgns_pkg::MAX_WIDTH);
    else                                             w = image_width;
    if (image_height < HW'(sgns_pkg::MIN_SIZE))        h = HW'(sgns_pkg::MIN_SIZE);
    else if (image_height > HW'(sgns_pkg::MAX_HEIGHT)) h = HW'(sgns_pkg::MAX_HEIGHT);
    else                                               h = image_height;
  end

  // pipeline control
  logic  adv, accept;
  logic  v1, v2, v3, v4, v5, v6, v7, v8, v9;
  item_t it1, it2, it3, it4, it5, it6, it7, it8, it9;
  item_t it0;

  assign adv      = !(v9 && it9.emit && out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // position of the incoming pixel
  logic [CW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic [WW-1:0] c0, c1;
  logic [HW-1:0] r0, r1;

  always_comb begin
    c0 = frame_start ? '0 : WW'(column_count);
    r0 = frame_start ? '0 : HW'(row_count);
    if (c0 >= w) begin
      c0 = '0;
      r0 = r0 + HW'(1);
    end
    if (r0 >= h) r0 = '0;

    it0.c  = c0[CW-1:0];
    it0.mc = (c0 >= WW'(1)) ? CW'(c0 - WW'(1)) : CW'(w - WW'(1));
    it0.grad_margin = c0 < WW'(sgns_pkg::BORDER + 1) || c0 >= w - WW'(2) ||
                      r0 < HW'(sgns_pkg::BORDER + 1) || r0 >= h - HW'(2);
    it0.sup_margin  = c0 < WW'(sgns_pkg::BORDER + 2) || c0 >= w - WW'(1) ||
                      r0 < HW'(sgns_pkg::BORDER + 2) || r0 >= h - HW'(1);
    it0.emit = r0 > HW'(2) || (r0 == HW'(2) && c0 >= WW'(2));
    it0.last = c0 == w - WW'(1) && r0 == h - HW'(1);

    c1 = c0 + WW'(1);
    r1 = r0 + HW'(1);
    if (c1 >= w) begin
      column_count_next = '0;
      row_count_next    = (r1 >= h) ? '0 : r1[RW-1:0];
    end else begin
      column_count_next = c1[CW-1:0];
      row_count_next    = r0[RW-1:0];
    end
  end

  // pixel line memory: {row r-2, row r-1}
  logic [15:0] pmem [sgns_pkg::MAX_WIDTH];
  logic [15:0] prd;
  logic [7:0]  pix1;

  always_ff @(posedge clk) begin
    if (adv) prd <= pmem[it0.c];
    if (adv && v1) pmem[it1.c] <= {prd[7:0], pix1};
  end

  // pixel window, [row][col], row 0 oldest
  logic [7:0] pw [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++) pw[i][k] <= '0;
    end else if (adv && v1) begin
      for (int i = 0; i < 3; i++) begin
        pw[i][0] <= pw[i][1];
        pw[i][1] <= pw[i][2];
      end
      pw[0][2] <= prd[15:8];
      pw[1][2] <= prd[7:0];
      pw[2][2] <= pix1;
    end
  end

  // stage 2: sobel sums
  logic [9:0]         gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [10:0] gx2, gy2, gx3, gy3;

  always_comb begin
    gx_pos = 10'(pw[0][2]) + 10'({pw[1][2], 1'b0}) + 10'(pw[2][2]);
    gx_neg = 10'(pw[0][0]) + 10'({pw[1][0], 1'b0}) + 10'(pw[2][0]);
    gy_pos = 10'(pw[0][0]) + 10'({pw[0][1], 1'b0}) + 10'(pw[0][2]);
    gy_neg = 10'(pw[2][0]) + 10'({pw[2][1], 1'b0}) + 10'(pw[2][2]);
    gx2 = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    gy2 = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
  end

  // stage 3: squares and tangent products
  logic [10:0] ngx, ngy;
  logic [9:0]  a3, b3;
  logic        opp3, gxz3;

  always_comb begin
    ngx  = 11'(-gx3);
    ngy  = 11'(-gy3);
    a3   = gx3[10] ? ngx[9:0] : gx3[9:0];
    b3   = gy3[10] ? ngy[9:0] : gy3[9:0];
    opp3 = (gy3 != '0) && (gx3[10] != gy3[10]);
    gxz3 = gx3 == '0;
  end

  logic [19:0] sqx4, sqy4;
  logic [35:0] p67_4;
  logic [32:0] p22_4;
  logic [9:0]  b4;
  logic        opp4, gxz4;

  // stage 4: sum of squares and direction bin
  logic [sgns_pkg::SUM_W-1:0] sum4;
  logic [35:0]                bs4;
  sgns_pkg::dir_t             dir4, dir5, dir6, dir7, dir8;

  always_comb begin
    sum4 = sgns_pkg::SUM_W'(sqx4) + sgns_pkg::SUM_W'(sqy4);
    bs4  = 36'({b4, 24'b0});
    if (gxz4)                   dir4 = sgns_pkg::DIR_HORZ;
    else if (bs4 > p67_4)       dir4 = sgns_pkg::DIR_VERT;
    else if (bs4 > 36'(p22_4))  dir4 = opp4 ? sgns_pkg::DIR_BACK : sgns_pkg::DIR_SLASH;
    else                        dir4 = sgns_pkg::DIR_HORZ;
  end

  logic [MW-1:0] root6, mag7, mag8;

  sgns_sqrt u_sqrt (
    .clk   (clk),
    .en    (adv),
    .value (sum4),
    .root  (root6)
  );

  // magnitude and direction line memory: {mag row above, mag row, dir}
  logic [2*MW+1:0] mmem [sgns_pkg::MAX_WIDTH];
  logic [2*MW+1:0] mrd;

  always_ff @(posedge clk) begin
    if (adv) mrd <= mmem[it7.mc];
    if (adv && v8) mmem[it8.mc] <= {mrd[MW+1:2], mag8, dir8};
  end

  // magnitude window and direction delay
  logic [MW-1:0]  mw [3][3];
  sgns_pkg::dir_t dir_delay, dcur9;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++) mw[i][k] <= '0;
      dir_delay <= sgns_pkg::DIR_VERT;
    end else if (adv && v8) begin
      for (int i = 0; i < 3; i++) begin
        mw[i][0] <= mw[i][1];
        mw[i][1] <= mw[i][2];
      end
      mw[0][2]  <= mrd[2*MW+1:MW+2];
      mw[1][2]  <= mrd[MW+1:2];
      mw[2][2]  <= mag8;
      dir_delay <= sgns_pkg::dir_t'(mrd[1:0]);
    end
  end

  // stage 9: suppression
  logic [MW-1:0] centre, n1, n2;
  logic [7:0]    val9;

  always_comb begin
    centre = mw[1][1];
    case (dcur9)
      sgns_pkg::DIR_VERT: begin
        n1 = mw[0][1];
        n2 = mw[2][1];
      end
      sgns_pkg::DIR_BACK: begin
        n1 = mw[0][0];
        n2 = mw[2][2];
      end
      sgns_pkg::DIR_HORZ: begin
        n1 = mw[1][0];
        n2 = mw[1][2];
      end
      default: begin
        n1 = mw[0][2];
        n2 = mw[2][0];
      end
    endcase
    if (!it9.sup_margin && centre > n1 && centre > n2)
      val9 = (centre > sgns_pkg::CLAMP_MAX) ? 8'hFF : centre[7:0];
    else
      val9 = '0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      {v1, v2, v3, v4, v5, v6, v7, v8, v9} <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end
      if (adv) begin
        v1 <= accept;
        {v2, v3, v4, v5, v6, v7, v8, v9} <= {v1, v2, v3, v4, v5, v6, v7, v8};
      end
      if (adv && v9 && it9.emit) out_valid <= 1'b1;
      else if (!out_stall)       out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      it1  <= it0;
      pix1 <= pixel;
      {it2, it3, it4, it5, it6, it7, it8, it9} <= {it1, it2, it3, it4, it5, it6, it7, it8};
      gx3  <= gx2;
      gy3  <= gy2;
      sqx4 <= a3 * a3;
      sqy4 <= b3 * b3;
      p67_4 <= sgns_pkg::TAN67_Q24 * a3;
      p22_4 <= sgns_pkg::TAN22_Q24 * a3;
      b4   <= b3;
      opp4 <= opp3;
      gxz4 <= gxz3;
      dir5 <= dir4;
      dir6 <= dir5;
      dir7 <= it6.grad_margin ? sgns_pkg::DIR_HORZ : dir6;
      mag7 <= it6.grad_margin ? '0 : root6;
      dir8 <= dir7;
      mag8 <= mag7;
      dcur9 <= dir_delay;
      if (v9 && it9.emit) begin
        edge_value    <= val9;
        last_of_frame <= it9.last;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/sgns_checker.sv]
`default_nettype none
module sgns_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          psel,
  input wire logic                          penable,
  input wire logic                          pwrite,
  input wire logic [sgns_pkg::PADDR_W-1:0]  paddr,
  input wire logic [31:0]                   pwdata,
  input wire logic [31:0]                   prdata,
  input wire logic                          pready,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic [7:0]                    pixel,
  input wire logic                          frame_start,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [7:0]                    edge_value,
  input wire logic                          last_of_frame
);

  // a held result stays until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(edge_value) && $stable(last_of_frame))
    else $error("output result dropped or changed while stalled");

  // input backpressure only comes from a stalled, full output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // the frame's last result lies on the border
  a_last_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_frame |-> edge_value == 8'd0)
    else $error("nonzero edge value on last result of frame");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind sobel_gradient_nonmax_suppress_core sgns_checker u_sgns_checker (.*);
`default_nettype wire
